/* rtl/core/p448_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p448_pkg
// Shared types and constants for the p448 field arithmetic unit.
// ----------------------------------------------------------------------------
package p448_pkg;

  localparam int LIMB_COUNT = 16;
  localparam int LIMB_BITS  = 28;
  localparam int IDX_W      = 4;   // limb index bits
  localparam int IN_W       = 29;  // input limb width
  localparam int OUT_W      = 31;  // result limb width
  localparam int ACC_W      = 64;  // working coefficient width

  // operation codes
  localparam logic [2:0] FUNC_MUL   = 3'd0;
  localparam logic [2:0] FUNC_SQR   = 3'd1;
  localparam logic [2:0] FUNC_ADD   = 3'd2;
  localparam logic [2:0] FUNC_SUB   = 3'd3;
  localparam logic [2:0] FUNC_CARRY = 3'd4;

  // tag that travels with each product through the datapath
  typedef struct packed {
    logic             en;     // contribution counts
    logic             dbl;    // contribution weighs twice
    logic             last;   // closes the current result limb
    logic [IDX_W-1:0] limb;   // result limb index
  } p448_tag_t;

  // 2p spread over the limbs
  function automatic logic [ACC_W-1:0] twice_p(input logic [IDX_W-1:0] k);
    logic [ACC_W-1:0] v;
    v = 64'h1ffffffe;
    if (k == 4'd8) v = 64'h3ffffffc;
    if (k == 4'd9) v = 64'h1ffffffc;
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/p448_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p448_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module p448_ram #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 16
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/p448_field_alu.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p448_field_alu
// Multiply, square, add, subtract and carry pass on one element mod
// 2^448-2^224-1, loaded as 16 limb transactions and returned as 16 limbs.
// ----------------------------------------------------------------------------
// channel  dir  tdata                          tuser   tlast
// s_axis   in   a_limb[28:0], b_limb[57:29]    func    -
// m_axis   out  out_limb[30:0]                 -       last_limb
//
// Loading stores one limb pair per transaction. Multiply and square then run
// 16 x 48 steps through one 29 x 29 multiplier (one limb product a cycle,
// columns folded straight into each result limb) behind the registered RAM
// read and the product register; add, subtract and carry-only take one step per limb.
// Emission returns 16 limbs, with the wrapped top carry applied to limbs 0-2
// and 8-10 as they leave. Synchronous reset clears the sequencer, the pipeline
// tag and output valid. The output register lets the next run start loading
// while the final limb is held.
// ----------------------------------------------------------------------------
module p448_field_alu (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,   // a_limb[28:0], b_limb[57:29], zero pad
  input  wire  [2:0]  s_axis_tuser,   // func[2:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_limb[30:0], zero pad
  output logic        m_axis_tlast
);
  import p448_pkg::*;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]       state;
  logic [IDX_W-1:0] load_count;
  logic [2:0]       func;
  logic             is_mul, is_sqr, use_carry;

  // operand stores
  logic             s_fire;
  logic [IN_W-1:0]  a_rd, b_rd, ac_rd, y_rd;
  logic [IDX_W-1:0] a_raddr, y_raddr;

  assign s_axis_tready = (state == ST_LOAD);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  p448_ram #(.WIDTH(IN_W), .DEPTH(LIMB_COUNT)) u_a_ram (
    .clk(clk), .we(s_fire), .waddr(load_count), .wdata(s_axis_tdata[28:0]),
    .raddr(a_raddr), .rdata(a_rd));
  p448_ram #(.WIDTH(IN_W), .DEPTH(LIMB_COUNT)) u_b_ram (
    .clk(clk), .we(s_fire), .waddr(load_count), .wdata(s_axis_tdata[57:29]),
    .raddr(y_raddr), .rdata(b_rd));
  // second copy of a for the other operand of a square
  p448_ram #(.WIDTH(IN_W), .DEPTH(LIMB_COUNT)) u_ac_ram (
    .clk(clk), .we(s_fire), .waddr(load_count), .wdata(s_axis_tdata[28:0]),
    .raddr(y_raddr), .rdata(ac_rd));

  assign is_mul    = (func == FUNC_MUL) || (func == FUNC_SQR);
  assign is_sqr    = (func == FUNC_SQR);
  assign use_carry = !((func == FUNC_ADD) || (func == FUNC_SUB));
  assign y_rd      = is_sqr ? ac_rd : b_rd;

  // issue counters: result limb, column term, row
  logic [IDX_W-1:0] im, ii;
  logic [1:0]       it;
  logic [4:0]       col;
  logic [5:0]       jj;
  logic             term_ok, iss_last;
  p448_tag_t        iss_tag, tag1, tag2;

  always_comb begin
    col     = 5'd0;
    term_ok = 1'b1;
    if (!im[3]) begin
      case (it)
        2'd0:    col = {1'b0, im};
        2'd1:    col = {1'b0, im} + 5'd16;
        default: begin
          col     = {1'b0, im} + 5'd24;
          term_ok = (im != 4'd7);
        end
      endcase
    end else begin
      case (it)
        2'd0:    col = {1'b0, im};
        2'd1:    col = {1'b0, im} + 5'd8;
        default: begin
          col     = {1'b0, im} + 5'd16;
          term_ok = (im != 4'd15);
        end
      endcase
    end
    jj       = {1'b0, col} - {2'b00, ii};
    iss_last = is_mul ? ((it == 2'd2) && (ii == 4'd15)) : 1'b1;
    a_raddr  = is_mul ? ii : im;
    y_raddr  = is_mul ? jj[3:0] : im;
    iss_tag.en   = is_mul ? (term_ok && (jj[5:4] == 2'b00)) : 1'b1;
    iss_tag.dbl  = is_mul && im[3] && (it == 2'd2);
    iss_tag.last = iss_last;
    iss_tag.limb = im;
  end

  // datapath stage two: product or limbwise operation
  logic [ACC_W-1:0] prod;
  logic [ACC_W-1:0] acc, sum, cin, v, r;
  logic             s3_done;

  always_ff @(posedge clk) begin
    case (func)
      FUNC_MUL, FUNC_SQR: prod <= {6'd0, {29'd0, a_rd} * {29'd0, y_rd}};
      FUNC_ADD:  prod <= {35'd0, a_rd} + {35'd0, y_rd};
      FUNC_SUB:  prod <= {35'd0, a_rd} + twice_p(tag1.limb) - {35'd0, y_rd};
      default:   prod <= {35'd0, a_rd};
    endcase
  end

  always_comb begin
    sum = acc;
    if (tag2.en) sum = acc + (tag2.dbl ? {prod[ACC_W-2:0], 1'b0} : prod);
    v = use_carry ? (sum + cin) : sum;
  end

  assign s3_done = tag2.last && (tag2.limb == 4'd15) && (state == ST_WAIT);

  // result limb shift line
  logic [OUT_W-1:0] t_sh [LIMB_COUNT];
  logic             sh_push, sh_pop;
  logic [OUT_W-1:0] t_in;
  logic [IDX_W-1:0] e;
  logic [36:0]      val;
  logic [9:0]       cf;
  logic [OUT_W-1:0] out_val;
  logic             emit_fire;

  assign sh_push   = tag2.last && ((state == ST_CALC) || (state == ST_WAIT));
  assign emit_fire = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);
  assign sh_pop    = emit_fire;
  assign t_in      = use_carry ? {3'd0, v[LIMB_BITS-1:0]} : v[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (sh_push || sh_pop) begin
      for (int k = 0; k < LIMB_COUNT - 1; k++) t_sh[k] <= t_sh[k+1];
      t_sh[LIMB_COUNT-1] <= sh_push ? t_in : '0;
    end
  end

  // accumulator, running carry and wrapped top carry
  always_ff @(posedge clk) begin
    tag1 <= (state == ST_CALC) ? iss_tag : '0;
    if (state == ST_LOAD) begin
      acc <= '0;
      cin <= '0;
    end else if (sh_push) begin
      acc <= '0;
      cin <= {28'd0, v[ACC_W-1:LIMB_BITS]};
      if (tag2.limb == 4'd15) r <= {28'd0, v[ACC_W-1:LIMB_BITS]};
    end else if (tag2.en) begin
      acc <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag2 <= '0;
    end else begin
      tag2 <= (state == ST_CALC || state == ST_WAIT) ? tag1 : '0;
    end
  end

  // emission fixups for the wrapped top carry
  always_comb begin
    val     = {6'd0, t_sh[0]};
    out_val = t_sh[0];
    if (use_carry) begin
      if (e == 4'd0 || e == 4'd8)
        val = {6'd0, t_sh[0]} + r[36:0];
      else if (e == 4'd1 || e == 4'd2 || e == 4'd9 || e == 4'd10)
        val = {6'd0, t_sh[0]} + {27'd0, cf};
      if (e == 4'd0 || e == 4'd1 || e == 4'd8 || e == 4'd9)
        out_val = {3'd0, val[LIMB_BITS-1:0]};
      else
        out_val = val[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) cf <= val[36:27] >> 1;
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      load_count    <= '0;
      im            <= '0;
      it            <= '0;
      ii            <= '0;
      e             <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready && !emit_fire) m_axis_tvalid <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (s_fire) begin
            load_count <= load_count + 4'd1;
            if (load_count == 4'd15) begin
              func  <= s_axis_tuser;
              state <= ST_CALC;
              im    <= '0;
              it    <= '0;
              ii    <= '0;
            end
          end
        end
        ST_CALC: begin
          if (is_mul && !iss_last) begin
            ii <= ii + 4'd1;
            if (ii == 4'd15) it <= it + 2'd1;
          end else begin
            ii <= '0;
            it <= '0;
            im <= im + 4'd1;
            if (im == 4'd15) state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (s3_done) begin
            state <= ST_EMIT;
            e     <= '0;
          end
        end
        default: begin
          if (emit_fire) begin
            m_axis_tvalid <= 1'b1;
            e             <= e + 4'd1;
            if (e == 4'd15) state <= ST_LOAD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_axis_tdata <= {1'b0, out_val};
      m_axis_tlast <= (e == 4'd15);
    end
  end

  // checks
  a_calc_after_load: assert property (@(posedge clk) disable iff (rst)
    (s_fire && load_count == 4'd15) |=> (state == ST_CALC))
    else $error("sixteenth load did not start the operation");

  a_emit_after_done: assert property (@(posedge clk) disable iff (rst)
    s3_done |=> (state == ST_EMIT))
    else $error("final limb did not start emission");

  a_linger_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (state == ST_CALC || state == ST_WAIT)) |-> m_axis_tlast)
    else $error("non-final limb pending during computation");

endmodule
`default_nettype wire

/* verif/p448_field_alu_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p448_field_alu_tb
// Loads runs of sixteen limb transactions with every operation code, predicts
// the sixteen result limbs of each run and checks them in order, with random
// gaps on both streams, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module p448_field_alu_tb;
  import p448_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  bit  hold_off   = 1'b0;
  int  idle_cycles = 0;

  always #4 clk = ~clk;

  p448_field_alu dut (.*);

  // predicted limbs of each finished run, in emission order
  class limb_scoreboard;
    logic [63:0] a_limbs [LIMB_COUNT];
    logic [63:0] b_limbs [LIMB_COUNT];
    int          loaded = 0;
    int          fail_count = 0;
    logic [31:0] limb_queue [$];
    bit          last_queue [$];

    // one line per mismatch
    task report(input string what);
      $display("mismatch: %s", what);
      fail_count++;
    endtask

    function void fold_carry(ref logic [63:0] v [LIMB_COUNT],
                             input int from, input int to);
      logic [63:0] h;
      h = v[from] >> LIMB_BITS;
      v[from] &= (64'd1 << LIMB_BITS) - 1;
      v[to] += h;
    endfunction

    function void carry_limbs(ref logic [63:0] v [LIMB_COUNT]);
      logic [63:0] top;
      for (int k = 0; k < LIMB_COUNT - 1; k++) fold_carry(v, k, k + 1);
      top = v[15] >> LIMB_BITS;
      v[15] &= (64'd1 << LIMB_BITS) - 1;
      v[0] += top;
      fold_carry(v, 0, 1);
      fold_carry(v, 1, 2);
      v[8] += top;
      fold_carry(v, 8, 9);
      fold_carry(v, 9, 10);
    endfunction

    function void field_product(ref logic [63:0] res [LIMB_COUNT],
                                input bit squaring);
      logic [63:0] col [2*LIMB_COUNT-1];
      for (int k = 0; k < 2*LIMB_COUNT-1; k++) col[k] = '0;
      for (int i = 0; i < LIMB_COUNT; i++)
        for (int j = 0; j < LIMB_COUNT; j++)
          col[i+j] += a_limbs[i] * (squaring ? a_limbs[j] : b_limbs[j]);
      // 2^448 = 2^224 + 1
      for (int k = 2*LIMB_COUNT-2; k >= LIMB_COUNT; k--) begin
        col[k-16] += col[k];
        col[k-8]  += col[k];
      end
      for (int k = 0; k < LIMB_COUNT; k++) res[k] = col[k];
    endfunction

    function void note_input(input logic [28:0] a, input logic [28:0] b,
                             input logic [2:0] op);
      logic [63:0] res [LIMB_COUNT];
      a_limbs[loaded] = {35'd0, a};
      b_limbs[loaded] = {35'd0, b};
      if (loaded != LIMB_COUNT - 1) begin
        loaded++;
        return;
      end
      loaded = 0;
      case (op)
        FUNC_MUL: begin field_product(res, 1'b0); carry_limbs(res); end
        FUNC_SQR: begin field_product(res, 1'b1); carry_limbs(res); end
        FUNC_ADD: for (int k = 0; k < LIMB_COUNT; k++) res[k] = a_limbs[k] + b_limbs[k];
        FUNC_SUB:
          for (int k = 0; k < LIMB_COUNT; k++)
            res[k] = a_limbs[k] + (twice_p(4'(k)) - b_limbs[k]);
        default: begin
          for (int k = 0; k < LIMB_COUNT; k++) res[k] = a_limbs[k];
          carry_limbs(res);
        end
      endcase
      for (int k = 0; k < LIMB_COUNT; k++) begin
        limb_queue.push_back({1'b0, res[k][30:0]});
        last_queue.push_back(k == LIMB_COUNT - 1);
      end
    endfunction

    task check_result(input logic [31:0] data, input logic last);
      logic [31:0] want;
      bit          want_last;
      if (limb_queue.size() == 0) begin
        report($sformatf("unexpected limb %h", data));
        return;
      end
      want = limb_queue.pop_front();
      want_last = last_queue.pop_front();
      if (data !== want) report($sformatf("limb got %h want %h", data, want));
      if (last !== want_last) report($sformatf("tlast got %b want %b", last, want_last));
    endtask
  endclass

  limb_scoreboard board = new();

  // one input transaction, then a random gap
  task automatic send_limb(input logic [28:0] a, input logic [28:0] b,
                           input logic [2:0] op);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, b, a};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_input(a, b, op);
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // input side goes quiet
  task automatic stop_sending;
    s_axis_tvalid <= 1'b0;
  endtask

  // a whole element; style 0 random, 1 all ones, 2 zeros, 3 28-bit tops
  task automatic send_run(input logic [2:0] op, input int style);
    logic [28:0] a, b;
    for (int k = 0; k < LIMB_COUNT; k++) begin
      case (style)
        1: begin a = '1; b = '1; end
        2: begin a = '0; b = '0; end
        3: begin a = 29'h0fffffff; b = 29'h0fffffff; end
        default: begin
          a = 29'($urandom()); b = 29'($urandom());
          if ($urandom_range(0, 3) != 0) begin a[28] = 1'b0; b[28] = 1'b0; end
        end
      endcase
      send_limb(a, b, k == LIMB_COUNT - 1 ? op : 3'($urandom_range(0, 7)));
    end
  endtask

  task automatic wait_drained;
    while (board.limb_queue.size() != 0) @(posedge clk);
  endtask

  // result side with random stalls and the long hold-off
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 10) < 4) ? 1'b0 : 1'b1;
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata, m_axis_tlast);
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed runs: every code, extremes of the limbs
    send_run(FUNC_MUL, 1);
    send_run(FUNC_SQR, 1);
    send_run(FUNC_ADD, 1);
    send_run(FUNC_SUB, 2);
    send_run(FUNC_SUB, 1);
    send_run(FUNC_CARRY, 1);
    send_run(3'd5, 3);
    send_run(3'd6, 0);
    send_run(3'd7, 0);
    send_run(FUNC_MUL, 2);
    send_run(FUNC_MUL, 3);
    // pause until everything has come out
    stop_sending();
    wait_drained();
    // long hold-off on the result side while runs keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (1500) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (3) send_run(3'($urandom_range(0, 4)), 0);
    join
    for (int r = 0; r < 12; r++)
      send_run(3'($urandom_range(0, 9) < 8 ? $urandom_range(0, 4) : $urandom_range(5, 7)), 0);
    stop_sending();
    wait_drained();
    repeat (40) @(posedge clk);
    if (board.fail_count == 0 && board.limb_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/core/p448_pkg.sv
rtl/core/p448_ram.sv
rtl/core/p448_field_alu.sv
verif/p448_field_alu_tb.sv
